FILE: hw/rtl/abl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abl_pkg
// Shared widths, stage counts and types of the ARGB source-over blender.
// ----------------------------------------------------------------------------
package abl_pkg;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 32;
    localparam int ALPHA_SH  = 24;
    localparam int ALPHA_W   = CH_W + 1;
    localparam int PROD_W    = 2 * CH_W;
    localparam int NUM_W     = 2 * CH_W;
    localparam int DIV_STEPS = CH_W;
    localparam int LANES     = 3;
    localparam int NSTAGE    = 2 + DIV_STEPS;

    typedef logic [CH_W-1:0]    chan_t;
    typedef logic [ALPHA_W-1:0] alpha_t;
    typedef logic [NUM_W-1:0]   num_t;
    typedef logic [NSTAGE-1:0]  stage_en_t;
    typedef logic [DIV_STEPS-1:0][ALPHA_W-1:0] div_vec_t;
    typedef logic [LANES-1:0][CH_W-1:0]        lane_vec_t;

endpackage
`default_nettype wire

FILE: hw/rtl/argb_alpha_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// argb_alpha_blend
// Source-over compositing of a foreground ARGB8888 pixel onto a background
// pixel, with three colour lanes working side by side.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   fg_pixel, bg_pixel
//   output    out        out_valid / out_stall out_alpha, out_red, out_green,
//                                              out_blue, zero_alpha
//
// One beat is taken every cycle unless a stall reaches the input; beats pass
// the two weighting stages, the eight-step divider and the output register.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stalled output holds its beat, and bubbles in the pipeline still let new
// beats in until every stage is full.
// ----------------------------------------------------------------------------
module argb_alpha_blend (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire logic [abl_pkg::PIX_W-1:0] fg_pixel,
    input  wire logic [abl_pkg::PIX_W-1:0] bg_pixel,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [abl_pkg::ALPHA_W-1:0] out_alpha,
    output logic [abl_pkg::CH_W-1:0]    out_red,
    output logic [abl_pkg::CH_W-1:0]    out_green,
    output logic [abl_pkg::CH_W-1:0]    out_blue,
    output logic       zero_alpha
);

    localparam int N = abl_pkg::NSTAGE;

    logic [N:0]         v_reg;
    logic [N:0]         rdy;
    abl_pkg::stage_en_t en;
    logic               en_out;
    abl_pkg::chan_t     fg_a;
    abl_pkg::chan_t     bg_weight;
    abl_pkg::div_vec_t  div_a;
    abl_pkg::alpha_t    final_a;
    abl_pkg::lane_vec_t quot;

    always_comb
    begin
        rdy[N] = !v_reg[N] || !out_stall;
        for (int k = N - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        en[0] = rdy[0] && in_valid;
        for (int k = 1; k < N; k++)
        begin
            en[k] = rdy[k] && v_reg[k-1];
        end
    end

    assign en_out    = rdy[N] && v_reg[N-1];
    assign in_stall  = !rdy[0];
    assign out_valid = v_reg[N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k <= N; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign fg_a = fg_pixel[abl_pkg::ALPHA_SH +: abl_pkg::CH_W];

    abl_alpha u_alpha (
        .clk       (clk),
        .en        (en),
        .fg_a      (fg_a),
        .bg_a      (bg_pixel[abl_pkg::ALPHA_SH +: abl_pkg::CH_W]),
        .bg_weight (bg_weight),
        .div_a     (div_a),
        .final_a   (final_a)
    );

    for (genvar l = 0; l < abl_pkg::LANES; l++)
    begin : g_lane
        localparam int OFS = (abl_pkg::LANES - 1 - l) * abl_pkg::CH_W;

        abl_lane u_lane (
            .clk       (clk),
            .en        (en),
            .fg_c      (fg_pixel[OFS +: abl_pkg::CH_W]),
            .bg_c      (bg_pixel[OFS +: abl_pkg::CH_W]),
            .fg_a      (fg_a),
            .bg_weight (bg_weight),
            .div_a     (div_a),
            .quot      (quot[l])
        );
    end

    abl_merge u_merge (
        .clk        (clk),
        .en         (en_out),
        .final_a    (final_a),
        .quot       (quot),
        .out_alpha  (out_alpha),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .zero_alpha (zero_alpha)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/abl_alpha.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abl_alpha
// Alpha path: alpha product, background weight, combined alpha and its
// delay line that feeds the divider steps of every lane.
// ----------------------------------------------------------------------------
module abl_alpha (
    input  wire logic              clk,
    input  wire abl_pkg::stage_en_t en,
    input  wire abl_pkg::chan_t    fg_a,
    input  wire abl_pkg::chan_t    bg_a,
    output abl_pkg::chan_t         bg_weight,
    output abl_pkg::div_vec_t      div_a,
    output abl_pkg::alpha_t        final_a
);

    logic [abl_pkg::PROD_W-1:0] prod_full;
    abl_pkg::chan_t             af_reg;
    abl_pkg::chan_t             ab_reg;
    abl_pkg::chan_t             prod_reg;
    abl_pkg::alpha_t            a_reg [1:abl_pkg::NSTAGE-1];

    assign prod_full = {{abl_pkg::CH_W{1'b0}}, fg_a} * {{abl_pkg::CH_W{1'b0}}, bg_a};
    assign bg_weight = ab_reg - prod_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            af_reg   <= fg_a;
            ab_reg   <= bg_a;
            prod_reg <= prod_full[abl_pkg::PROD_W-1:abl_pkg::CH_W];
        end
        if (en[1])
        begin
            a_reg[1] <= {1'b0, af_reg} + {1'b0, bg_weight};
        end
    end

    for (genvar s = 2; s < abl_pkg::NSTAGE; s++)
    begin : g_delay
        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                a_reg[s] <= a_reg[s-1];
            end
        end
    end

    for (genvar j = 0; j < abl_pkg::DIV_STEPS; j++)
    begin : g_div
        assign div_a[j] = a_reg[j+1];
    end

    assign final_a = a_reg[abl_pkg::NSTAGE-1];

endmodule
`default_nettype wire

FILE: hw/rtl/abl_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abl_lane
// One colour channel: weighted sum of both pixels, then an eight-step
// pipelined restoring divider by the combined alpha.
// ----------------------------------------------------------------------------
module abl_lane (
    input  wire logic              clk,
    input  wire abl_pkg::stage_en_t en,
    input  wire abl_pkg::chan_t    fg_c,
    input  wire abl_pkg::chan_t    bg_c,
    input  wire abl_pkg::chan_t    fg_a,
    input  wire abl_pkg::chan_t    bg_weight,
    input  wire abl_pkg::div_vec_t div_a,
    output abl_pkg::chan_t         quot
);

    localparam int TW = abl_pkg::NUM_W + 1;

    logic [abl_pkg::PROD_W-1:0] fterm_reg;
    abl_pkg::chan_t             cb_reg;
    logic [abl_pkg::PROD_W-1:0] bterm;
    logic [TW-1:0]              sum;
    abl_pkg::num_t              rem_reg [1:abl_pkg::NSTAGE-1];
    abl_pkg::chan_t             q_reg   [1:abl_pkg::NSTAGE-1];

    assign bterm = {{abl_pkg::CH_W{1'b0}}, cb_reg} * {{abl_pkg::CH_W{1'b0}}, bg_weight};
    assign sum   = {1'b0, fterm_reg} + {1'b0, bterm};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            fterm_reg <= {{abl_pkg::CH_W{1'b0}}, fg_c} * {{abl_pkg::CH_W{1'b0}}, fg_a};
            cb_reg    <= bg_c;
        end
        if (en[1])
        begin
            rem_reg[1] <= sum[abl_pkg::NUM_W-1:0];
            q_reg[1]   <= '0;
        end
    end

    for (genvar j = 0; j < abl_pkg::DIV_STEPS; j++)
    begin : g_step
        localparam int SH = abl_pkg::DIV_STEPS - 1 - j;
        logic [TW-1:0] dsh;
        logic [TW-1:0] trial;

        assign dsh   = TW'(div_a[j]) << SH;
        assign trial = {1'b0, rem_reg[j+1]} - dsh;

        always_ff @(posedge clk)
        begin
            if (en[j+2])
            begin
                if (!trial[TW-1])
                begin
                    rem_reg[j+2] <= trial[abl_pkg::NUM_W-1:0];
                end
                else
                begin
                    rem_reg[j+2] <= rem_reg[j+1];
                end
                q_reg[j+2] <= {q_reg[j+1][abl_pkg::CH_W-2:0], ~trial[TW-1]};
            end
        end
    end

    assign quot = q_reg[abl_pkg::NSTAGE-1];

endmodule
`default_nettype wire

FILE: hw/rtl/abl_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abl_merge
// Output register: gathers the three lane quotients and the combined alpha,
// and forces the colour channels to zero when the combined alpha is zero.
// ----------------------------------------------------------------------------
module abl_merge (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire abl_pkg::alpha_t    final_a,
    input  wire abl_pkg::lane_vec_t quot,
    output abl_pkg::alpha_t         out_alpha,
    output abl_pkg::chan_t          out_red,
    output abl_pkg::chan_t          out_green,
    output abl_pkg::chan_t          out_blue,
    output logic                    zero_alpha
);

    logic is_zero;

    assign is_zero = (final_a == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_alpha  <= final_a;
            zero_alpha <= is_zero;
            out_red    <= is_zero ? '0 : quot[0];
            out_green  <= is_zero ? '0 : quot[1];
            out_blue   <= is_zero ? '0 : quot[2];
        end
    end

endmodule
`default_nettype wire

FILE: dv/argb_alpha_blend_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb_alpha_blend_tb
// Self-checking bench for the source-over ARGB8888 blender. A scoreboard
// class predicts the composited pixel for every input beat and compares each
// output beat against the oldest prediction. The stimulus runs directed
// corner pixels first, then random pixel pairs under random gaps, gap-free
// streaming, and a long output hold that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module argb_alpha_blend_tb;

    localparam int          MAX_WAIT     = 11;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int unsigned CHAN_MAX     = (1 << abl_pkg::CH_W) - 1;

    typedef struct packed {
        abl_pkg::alpha_t alpha;
        abl_pkg::chan_t  red;
        abl_pkg::chan_t  green;
        abl_pkg::chan_t  blue;
        logic            zero;
    } blend_result_t;

    class blend_scoreboard;
        blend_result_t expected_q[$];
        int unsigned   mismatches;
        int unsigned   pixels_in;
        int unsigned   pixels_out;
        int unsigned   zero_pairs;

        function new();
            mismatches = 0;
            pixels_in  = 0;
            pixels_out = 0;
            zero_pairs = 0;
        endfunction

        function abl_pkg::chan_t mix_channel(int unsigned cf, int unsigned cb,
                                             int unsigned af, int unsigned bw,
                                             int unsigned a);
            int unsigned q;
            q = (cf * af + cb * bw) / a;
            if (q > CHAN_MAX)
            begin
                q = CHAN_MAX;
            end
            return abl_pkg::chan_t'(q);
        endfunction

        function blend_result_t blend_pixel(logic [abl_pkg::PIX_W-1:0] fg,
                                            logic [abl_pkg::PIX_W-1:0] bg);
            blend_result_t res;
            int unsigned   af;
            int unsigned   ab;
            int unsigned   bw;
            int unsigned   a;
            af  = 32'(fg[abl_pkg::ALPHA_SH +: abl_pkg::CH_W]);
            ab  = 32'(bg[abl_pkg::ALPHA_SH +: abl_pkg::CH_W]);
            bw  = ab - ((af * ab) >> abl_pkg::CH_W);
            a   = af + bw;
            res = '0;
            res.alpha = abl_pkg::alpha_t'(a);
            if (a == 0)
            begin
                res.zero = 1'b1;
            end
            else
            begin
                res.red   = mix_channel(32'(fg[23:16]), 32'(bg[23:16]), af, bw, a);
                res.green = mix_channel(32'(fg[15:8]), 32'(bg[15:8]), af, bw, a);
                res.blue  = mix_channel(32'(fg[7:0]), 32'(bg[7:0]), af, bw, a);
            end
            return res;
        endfunction

        function void note_input(logic [abl_pkg::PIX_W-1:0] fg,
                                 logic [abl_pkg::PIX_W-1:0] bg);
            blend_result_t res;
            res = blend_pixel(fg, bg);
            if (res.zero)
            begin
                zero_pairs++;
            end
            expected_q.push_back(res);
            pixels_in++;
        endfunction

        function void check_result(blend_result_t got);
            blend_result_t want;
            pixels_out++;
            if (expected_q.size() == 0)
            begin
                $error("Output beat arrived with no pixel pair outstanding.");
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.alpha !== want.alpha)
            begin
                $error("out_alpha: expected %0d, actual %0d", want.alpha, got.alpha);
                mismatches++;
            end
            if (got.red !== want.red)
            begin
                $error("out_red: expected %0d, actual %0d", want.red, got.red);
                mismatches++;
            end
            if (got.green !== want.green)
            begin
                $error("out_green: expected %0d, actual %0d", want.green, got.green);
                mismatches++;
            end
            if (got.blue !== want.blue)
            begin
                $error("out_blue: expected %0d, actual %0d", want.blue, got.blue);
                mismatches++;
            end
            if (got.zero !== want.zero)
            begin
                $error("zero_alpha: expected %0d, actual %0d", want.zero, got.zero);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [abl_pkg::PIX_W-1:0] fg_pixel;
    logic [abl_pkg::PIX_W-1:0] bg_pixel;
    logic                      out_valid;
    logic                      out_stall;
    abl_pkg::alpha_t           out_alpha;
    abl_pkg::chan_t            out_red;
    abl_pkg::chan_t            out_green;
    abl_pkg::chan_t            out_blue;
    logic                      zero_alpha;

    logic                      send_gaps;
    logic                      recv_gaps;
    logic                      hold_req;
    blend_scoreboard           sb;

    argb_alpha_blend u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .fg_pixel   (fg_pixel),
        .bg_pixel   (bg_pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_alpha  (out_alpha),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .zero_alpha (zero_alpha)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        sb = new();
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall === 1'b0)
        begin
            sb.note_input(fg_pixel, bg_pixel);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            sb.check_result('{out_alpha, out_red, out_green, out_blue, zero_alpha});
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("argb_alpha_blend verification failed");
        $finish;
    end

    initial
    begin
        int unsigned wait_cycles;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (recv_gaps)
            begin
                wait_cycles = $urandom_range(0, MAX_WAIT);
                if (wait_cycles > 0)
                begin
                    out_stall = 1'b1;
                    repeat (wait_cycles) @(negedge clk);
                end
            end
            out_stall = 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            @(negedge clk);
        end
    end

    task automatic send_pixel(input logic [abl_pkg::PIX_W-1:0] fg,
                              input logic [abl_pkg::PIX_W-1:0] bg);
        int unsigned gap;
        gap = send_gaps ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap)
            begin
                fg_pixel = $urandom;
                bg_pixel = $urandom;
                @(negedge clk);
            end
        end
        fg_pixel = fg;
        bg_pixel = bg;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        @(negedge clk);
    endtask

    function automatic abl_pkg::chan_t edge_alpha();
        abl_pkg::chan_t a;
        case ($urandom_range(0, 3))
            0:       a = 8'd0;
            1:       a = 8'd1;
            2:       a = 8'd254;
            default: a = 8'd255;
        endcase
        return a;
    endfunction

    task automatic send_random(input int count);
        abl_pkg::chan_t fa;
        abl_pkg::chan_t ba;
        for (int i = 0; i < count; i++)
        begin
            fa = abl_pkg::chan_t'($urandom);
            ba = abl_pkg::chan_t'($urandom);
            case ($urandom_range(0, 9))
                0:
                begin
                    fa = 8'd0;
                    ba = 8'd0;
                end
                1:       fa = edge_alpha();
                2:       ba = edge_alpha();
                default: ;
            endcase
            send_pixel({fa, 24'($urandom)}, {ba, 24'($urandom)});
        end
    endtask

    task automatic run_directed();
        send_pixel(32'h0000_0000, 32'h0000_0000);
        send_pixel(32'h00FF_FFFF, 32'h00FF_FFFF);
        send_pixel(32'h0012_3456, 32'h00AB_CDEF);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(32'hFF00_0000, 32'hFF00_0000);
        send_pixel(32'hFFFF_0000, 32'hFF00_FF00);
        send_pixel(32'h00FF_FFFF, 32'hFF00_0000);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(32'h01FF_FFFF, 32'h0100_0000);
        send_pixel(32'h0100_0000, 32'h01FF_FFFF);
        send_pixel(32'h00FF_FFFF, 32'h01FF_FFFF);
        send_pixel(32'h01FF_FFFF, 32'h0000_0000);
        send_pixel(32'h80FF_FFFF, 32'h80FF_FFFF);
        send_pixel(32'h8000_0000, 32'hFFFF_FFFF);
        send_pixel(32'hAAAA_AAAA, 32'h5555_5555);
        send_pixel(32'h5555_5555, 32'hAAAA_AAAA);
        send_pixel(32'hFE01_FE01, 32'hFEFE_01FE);
        send_pixel(32'h7F80_7F80, 32'h817F_807F);
        send_pixel(32'hFF12_3456, 32'h01FF_FFFF);
    endtask

    initial
    begin
        in_valid  = 1'b0;
        fg_pixel  = '0;
        bg_pixel  = '0;
        rst_n     = 1'b0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        hold_req  = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        send_random(600);

        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        send_random(400);

        hold_req = 1'b1;
        send_random(150);

        send_gaps = 1'b1;
        send_random(250);

        send_gaps = 1'b0;
        recv_gaps = 1'b1;
        send_random(250);

        send_gaps = 1'b1;
        send_random(100);

        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Blended %0d pixel pairs (%0d with both alphas zero) and checked %0d beats,",
                 sb.pixels_in, sb.zero_pairs, sb.pixels_out);
        $display("through gapped, back-to-back and held-output phases.");
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("argb_alpha_blend verification clean");
        end
        else
        begin
            $display("argb_alpha_blend verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/abl_pkg.sv
hw/rtl/abl_alpha.sv
hw/rtl/abl_lane.sv
hw/rtl/abl_merge.sv
hw/rtl/argb_alpha_blend.sv
dv/argb_alpha_blend_tb.sv
